[hw/rtl/dtq_pkg.sv]
// dtq_pkg: shared types, constants and helpers for the deadline timer queue
// used by dtq_cell and deadline_timer_queue; no dependencies
`default_nettype none

package dtq_pkg;

	localparam int SLOTS_DEF   = 16;
	localparam int MAX_RESULTS = 16;
	localparam int TIME_W      = 48;
	localparam int PERIOD_W    = 32;
	localparam int TAG_W       = 16;
	localparam int FUNC_W      = 3;
	localparam int SEL_W       = 4;

	localparam logic [PERIOD_W-1:0] WINDOW_RESET = PERIOD_W'(60 * 60 * 1000);
	localparam logic [TIME_W-1:0]   TIME_MAX     = '1;

	localparam logic [FUNC_W-1:0] FN_ADD     = 3'd0;
	localparam logic [FUNC_W-1:0] FN_CANCEL  = 3'd1;
	localparam logic [FUNC_W-1:0] FN_REFRESH = 3'd2;
	localparam logic [FUNC_W-1:0] FN_RESET   = 3'd3;
	localparam logic [FUNC_W-1:0] FN_EXPIRE  = 3'd4;
	localparam logic [FUNC_W-1:0] FN_QUERY   = 3'd5;
	localparam logic [FUNC_W-1:0] FN_SPARE6  = 3'd6;
	localparam logic [FUNC_W-1:0] FN_SPARE7  = 3'd7;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_ADD,
		OP_CANCEL,
		OP_REFRESH,
		OP_BASE,
		OP_RESET,
		OP_DUE,
		OP_FIRE
	} cell_op_t;

	typedef struct packed {
		cell_op_t              op;
		logic [TIME_W-1:0]     now;
		logic [PERIOD_W-1:0]   period;
		logic                  repeats;
		logic                  start_now;
		logic [TAG_W-1:0]      tag;
		logic                  roll;
	} cell_cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_BASE,
		ST_RESET,
		ST_DUE,
		ST_SCAN,
		ST_FIRE,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic [SEL_W-1:0]  slot;
		logic [TAG_W-1:0]  tag;
		logic              ok;
		logic              fired;
		logic              wake;
		logic              none;
		logic [TIME_W-1:0] wait_ms;
		logic              last;
	} result_t;

	// deadline arithmetic saturates at the top of the time range
	function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] t,
			input logic [PERIOD_W-1:0] p);
		logic [TIME_W:0] s;
		s = {1'b0, t} + {(TIME_W - PERIOD_W + 1)'(0), p};
		return s[TIME_W] ? TIME_MAX : s[TIME_W-1:0];
	endfunction

endpackage

`default_nettype wire

[hw/rtl/dtq_cell.sv]
// dtq_cell: one timer slot plus one stage of the registered minimum-search chain
// depends on dtq_pkg
`default_nettype none

module dtq_cell #(
	parameter int SLOT_W = 4,
	parameter int IDX    = 0
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire dtq_pkg::cell_cmd_t             cmd,
	input  wire logic                           sel,
	input  wire logic                           scan_due,
	input  wire logic                           prev_found,
	input  wire logic [dtq_pkg::TIME_W-1:0]     prev_deadline,
	input  wire logic [SLOT_W-1:0]              prev_slot,
	output logic                                next_found,
	output logic [dtq_pkg::TIME_W-1:0]          next_deadline,
	output logic [SLOT_W-1:0]                   next_slot,
	output logic                                active,
	output logic [dtq_pkg::PERIOD_W-1:0]        period,
	output logic [dtq_pkg::TAG_W-1:0]           tag
);
	import dtq_pkg::*;

	logic                active_q;
	logic                rep_q;
	logic                due_q;
	logic [PERIOD_W-1:0] period_q;
	logic [TIME_W-1:0]   deadline_q;
	logic [TIME_W-1:0]   base_q;
	logic [TAG_W-1:0]    tag_q;

	logic [TIME_W-1:0]   add_a;
	logic [PERIOD_W-1:0] add_b;
	logic [TIME_W-1:0]   add_sum;
	logic                eligible;
	logic                take;

	// one shared saturating adder for every deadline update
	always_comb begin
		add_a = cmd.now;
		add_b = period_q;
		case (cmd.op)
			OP_ADD: begin
				add_b = cmd.period;
			end
			OP_RESET: begin
				add_a = cmd.start_now ? cmd.now : base_q;
				add_b = cmd.period;
			end
			default: begin
			end
		endcase
	end

	assign add_sum = sat_add(add_a, add_b);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q   <= 1'b0;
			rep_q      <= 1'b0;
			due_q      <= 1'b0;
			period_q   <= '0;
			deadline_q <= '0;
			base_q     <= '0;
			tag_q      <= '0;
		end else begin
			case (cmd.op)
				OP_ADD: begin
					if (sel) begin
						active_q   <= 1'b1;
						rep_q      <= cmd.repeats;
						period_q   <= cmd.period;
						deadline_q <= add_sum;
						tag_q      <= cmd.tag;
					end
				end
				OP_CANCEL: begin
					if (sel) begin
						active_q <= 1'b0;
					end
				end
				OP_REFRESH: begin
					if (sel) begin
						deadline_q <= add_sum;
					end
				end
				OP_BASE: begin
					// start of the current run, clamped at zero
					if (sel) begin
						base_q <= (deadline_q >= {(TIME_W - PERIOD_W)'(0), period_q})
							? deadline_q - {(TIME_W - PERIOD_W)'(0), period_q} : '0;
					end
				end
				OP_RESET: begin
					if (sel) begin
						period_q   <= cmd.period;
						deadline_q <= add_sum;
					end
				end
				OP_DUE: begin
					due_q <= active_q && (cmd.roll || deadline_q <= cmd.now);
				end
				OP_FIRE: begin
					if (sel) begin
						due_q <= 1'b0;
						if (rep_q) begin
							deadline_q <= add_sum;
						end else begin
							active_q <= 1'b0;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	// chain runs in slot order, so a tie keeps the earlier (lower) slot
	assign eligible = scan_due ? due_q : active_q;
	assign take     = eligible && (!prev_found || deadline_q < prev_deadline);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_found    <= 1'b0;
			next_deadline <= '0;
			next_slot     <= '0;
		end else begin
			next_found    <= prev_found || eligible;
			next_deadline <= take ? deadline_q : prev_deadline;
			next_slot     <= take ? SLOT_W'(IDX) : prev_slot;
		end
	end

	assign active = active_q;
	assign period = period_q;
	assign tag    = tag_q;

endmodule

`default_nettype wire

[hw/rtl/deadline_timer_queue.sv]
// deadline_timer_queue: timer table as a chain of slot cells with a control sequencer
// depends on dtq_pkg and dtq_cell
// cancel, refresh and rejected items go straight to the output register; add, query and
// reset from now scan the slot chain; reset from last start passes the base and reset states
// first; expire marks due slots, then scans and fires the earliest due timer after each scan;
// the queue takes one item at a time; reset clears all slots, the pending wake, the last expire time, window 1 h
`default_nettype none

module deadline_timer_queue #(
	parameter int SLOTS = dtq_pkg::SLOTS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic [dtq_pkg::FUNC_W-1:0]    func,
	input  wire logic [dtq_pkg::TIME_W-1:0]    now_ms,
	input  wire logic [dtq_pkg::SEL_W-1:0]     slot_sel,
	input  wire logic [dtq_pkg::PERIOD_W-1:0]  period_ms,
	input  wire logic                          repeats,
	input  wire logic                          start_now,
	input  wire logic [dtq_pkg::TAG_W-1:0]     tag_in,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [dtq_pkg::PERIOD_W-1:0]  cfg_data,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic [dtq_pkg::SEL_W-1:0]          slot_out,
	output logic [dtq_pkg::TAG_W-1:0]          tag_out,
	output logic                               ok,
	output logic                               fired,
	output logic                               front_wake,
	output logic                               none_pending,
	output logic [dtq_pkg::TIME_W-1:0]         wait_ms,
	output logic                               last
);
	import dtq_pkg::*;

	localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CNT_W  = $clog2(SLOTS + 1);
	localparam int N_W    = $clog2(MAX_RESULTS + 1);

	state_t state_q, state_d, emit_next_q, emit_next_d;

	logic [FUNC_W-1:0]   func_q;
	logic [TIME_W-1:0]   now_q;
	logic [SEL_W-1:0]    sel_q;
	logic [PERIOD_W-1:0] period_q;
	logic                rep_q;
	logic                fromnow_q;
	logic [TAG_W-1:0]    tag_q;

	logic [PERIOD_W-1:0] window_q;
	logic [TIME_W-1:0]   last_exp_q;
	logic                wake_q;
	logic                roll_q;
	logic                scan_due_q;
	logic [SLOT_W-1:0]   target_q;
	logic [SLOT_W-1:0]   fire_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [N_W-1:0]      n_q;
	logic                have_pend_q;
	logic [SLOT_W-1:0]   pend_slot_q;
	logic [TAG_W-1:0]    pend_tag_q;
	result_t             res_q, res_d, out_q;
	logic                res_load;
	logic                out_valid_q;

	cell_cmd_t           cmd;
	logic [SLOT_W-1:0]   cmd_idx;
	logic                cmd_hit;
	logic [SLOTS-1:0]    cell_sel;

	logic [SLOTS-1:0]    active_v;
	logic [PERIOD_W-1:0] period_a [SLOTS];
	logic [TAG_W-1:0]    tag_a [SLOTS];
	logic                found_c [SLOTS];
	logic [TIME_W-1:0]   dl_c [SLOTS];
	logic [SLOT_W-1:0]   slot_c [SLOTS];

	logic                in_accept;
	logic                out_free;
	logic                sel_in_range;
	logic [SLOT_W-1:0]   sel_idx;
	logic                sel_valid;
	logic                reset_skip;
	logic                free_ok;
	logic [SLOT_W-1:0]   free_idx;
	logic                roll;
	logic                scan_done;
	logic                best_found;
	logic [TIME_W-1:0]   best_dl;
	logic [SLOT_W-1:0]   best_slot;
	logic                wake_now;
	logic                fire_is_final;

	assign in_accept = in_valid && !in_stall;
	assign in_stall  = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;
	assign out_free  = !out_valid_q || !out_stall;

	assign sel_in_range = int'(sel_q) < SLOTS;
	assign sel_idx      = SLOT_W'(sel_q);
	assign sel_valid    = sel_in_range && active_v[sel_idx];
	assign reset_skip   = sel_in_range && (period_q == period_a[sel_idx]) && !fromnow_q;

	always_comb begin
		free_ok  = 1'b0;
		free_idx = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (!active_v[i]) begin
				free_ok  = 1'b1;
				free_idx = SLOT_W'(i);
			end
		end
	end

	// backward jump past the window counts as a rollover
	assign roll = (last_exp_q > {(TIME_W - PERIOD_W)'(0), window_q})
		&& (now_q < last_exp_q - {(TIME_W - PERIOD_W)'(0), window_q});

	assign scan_done     = (cnt_q == CNT_W'(SLOTS));
	assign best_found    = found_c[SLOTS-1];
	assign best_dl       = dl_c[SLOTS-1];
	assign best_slot     = slot_c[SLOTS-1];
	assign wake_now      = best_found && (best_slot == target_q) && !wake_q;
	assign fire_is_final = (n_q + N_W'(1)) == N_W'(MAX_RESULTS);

	// slot chain
	genvar g;
	generate
		for (g = 0; g < SLOTS; g++) begin : g_cell
			logic                prev_found;
			logic [TIME_W-1:0]   prev_deadline;
			logic [SLOT_W-1:0]   prev_slot;
			if (g == 0) begin : g_head
				assign prev_found    = 1'b0;
				assign prev_deadline = '0;
				assign prev_slot     = '0;
			end else begin : g_link
				assign prev_found    = found_c[g-1];
				assign prev_deadline = dl_c[g-1];
				assign prev_slot     = slot_c[g-1];
			end
			dtq_cell #(
				.SLOT_W (SLOT_W),
				.IDX    (g)
			) u_cell (
				.clk           (clk),
				.arst_n        (arst_n),
				.cmd           (cmd),
				.sel           (cell_sel[g]),
				.scan_due      (scan_due_q),
				.prev_found    (prev_found),
				.prev_deadline (prev_deadline),
				.prev_slot     (prev_slot),
				.next_found    (found_c[g]),
				.next_deadline (dl_c[g]),
				.next_slot     (slot_c[g]),
				.active        (active_v[g]),
				.period        (period_a[g]),
				.tag           (tag_a[g])
			);
		end
	endgenerate

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_accept) state_d = ST_DECODE;
			end
			ST_DECODE: begin
				case (func_q)
					FN_ADD: state_d = free_ok ? ST_SCAN : ST_EMIT;
					FN_RESET: begin
						if (reset_skip || !sel_valid) state_d = ST_EMIT;
						else if (fromnow_q) state_d = ST_SCAN;
						else state_d = ST_BASE;
					end
					FN_EXPIRE: state_d = ST_DUE;
					FN_QUERY: state_d = ST_SCAN;
					default: state_d = ST_EMIT;
				endcase
			end
			ST_BASE: state_d = ST_RESET;
			ST_RESET: state_d = ST_SCAN;
			ST_DUE: state_d = ST_SCAN;
			ST_SCAN: begin
				if (scan_done) begin
					if (func_q == FN_EXPIRE && best_found && !have_pend_q) state_d = ST_FIRE;
					else state_d = ST_EMIT;
				end
			end
			ST_FIRE: state_d = fire_is_final ? ST_EMIT : ST_SCAN;
			ST_EMIT: begin
				if (out_free) state_d = emit_next_q;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs: cell commands and result staging
	always_comb begin
		cmd.op        = OP_NONE;
		cmd.now       = now_q;
		cmd.period    = period_q;
		cmd.repeats   = rep_q;
		cmd.start_now = fromnow_q;
		cmd.tag       = tag_q;
		cmd.roll      = roll_q;
		cmd_idx       = target_q;
		cmd_hit       = 1'b0;
		res_d         = '0;
		res_d.last    = 1'b1;
		res_load      = 1'b0;
		emit_next_d   = ST_IDLE;
		case (state_q)
			ST_DECODE: begin
				case (func_q)
					FN_ADD: begin
						if (free_ok) begin
							cmd.op  = OP_ADD;
							cmd_idx = free_idx;
							cmd_hit = 1'b1;
						end else begin
							res_load = 1'b1;
						end
					end
					FN_CANCEL, FN_REFRESH: begin
						if (sel_valid) begin
							cmd.op  = (func_q == FN_CANCEL) ? OP_CANCEL : OP_REFRESH;
							cmd_idx = sel_idx;
							cmd_hit = 1'b1;
						end
						res_d.ok = sel_valid;
						res_load = 1'b1;
					end
					FN_RESET: begin
						if (reset_skip) begin
							res_d.ok = 1'b1;
							res_load = 1'b1;
						end else if (!sel_valid) begin
							res_load = 1'b1;
						end else if (fromnow_q) begin
							cmd.op  = OP_RESET;
							cmd_idx = sel_idx;
							cmd_hit = 1'b1;
						end
					end
					FN_EXPIRE, FN_QUERY: begin
					end
					default: begin
						res_load = 1'b1;
					end
				endcase
			end
			ST_BASE: begin
				cmd.op  = OP_BASE;
				cmd_hit = 1'b1;
			end
			ST_RESET: begin
				cmd.op  = OP_RESET;
				cmd_hit = 1'b1;
			end
			ST_DUE: begin
				cmd.op = OP_DUE;
			end
			ST_SCAN: begin
				if (scan_done) begin
					res_d.ok = 1'b1;
					case (func_q)
						FN_ADD: begin
							res_d.slot = SEL_W'(target_q);
							res_d.wake = wake_now;
							res_load   = 1'b1;
						end
						FN_RESET: begin
							res_d.wake = wake_now;
							res_load   = 1'b1;
						end
						FN_QUERY: begin
							res_d.none    = !best_found;
							res_d.wait_ms = !best_found ? TIME_MAX
								: (now_q >= best_dl ? '0 : best_dl - now_q);
							res_load      = 1'b1;
						end
						default: begin
							// expire: the held beat goes out once we know if it is the last
							if (have_pend_q) begin
								res_d.slot  = SEL_W'(pend_slot_q);
								res_d.tag   = pend_tag_q;
								res_d.fired = 1'b1;
								res_d.last  = !best_found;
								res_load    = 1'b1;
								emit_next_d = best_found ? ST_FIRE : ST_IDLE;
							end else if (!best_found) begin
								res_load = 1'b1;
							end
						end
					endcase
				end
			end
			ST_FIRE: begin
				cmd.op  = OP_FIRE;
				cmd_idx = fire_q;
				cmd_hit = 1'b1;
				if (fire_is_final) begin
					res_d.slot  = SEL_W'(fire_q);
					res_d.tag   = tag_a[fire_q];
					res_d.ok    = 1'b1;
					res_d.fired = 1'b1;
					res_load    = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		cell_sel = '0;
		if (cmd_hit) cell_sel[cmd_idx] = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			emit_next_q <= ST_IDLE;
			window_q    <= WINDOW_RESET;
			last_exp_q  <= '0;
			wake_q      <= 1'b0;
			roll_q      <= 1'b0;
			scan_due_q  <= 1'b0;
			target_q    <= '0;
			fire_q      <= '0;
			cnt_q       <= '0;
			n_q         <= '0;
			have_pend_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= (state_q == ST_SCAN) ? cnt_q + CNT_W'(1) : '0;
			if (cfg_valid && cfg_ready) window_q <= cfg_data;
			if (res_load) emit_next_q <= emit_next_d;
			if (state_q == ST_EMIT && out_free) out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
			case (state_q)
				ST_DECODE: begin
					case (func_q)
						FN_ADD: begin
							target_q   <= free_idx;
							scan_due_q <= 1'b0;
						end
						FN_RESET: begin
							target_q   <= sel_idx;
							scan_due_q <= 1'b0;
						end
						FN_EXPIRE: begin
							roll_q      <= roll;
							last_exp_q  <= now_q;
							n_q         <= '0;
							have_pend_q <= 1'b0;
						end
						FN_QUERY: begin
							wake_q     <= 1'b0;
							scan_due_q <= 1'b0;
						end
						default: begin
						end
					endcase
				end
				ST_DUE: begin
					scan_due_q <= 1'b1;
				end
				ST_SCAN: begin
					if (scan_done) begin
						if ((func_q == FN_ADD || func_q == FN_RESET) && wake_now) wake_q <= 1'b1;
						if (func_q == FN_EXPIRE && best_found) fire_q <= best_slot;
					end
				end
				ST_FIRE: begin
					have_pend_q <= 1'b1;
					n_q         <= n_q + N_W'(1);
				end
				default: begin
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_accept) begin
			func_q    <= func;
			now_q     <= now_ms;
			sel_q     <= slot_sel;
			period_q  <= period_ms;
			rep_q     <= repeats;
			fromnow_q <= start_now;
			tag_q     <= tag_in;
		end
		if (res_load) res_q <= res_d;
		if (state_q == ST_FIRE) begin
			pend_slot_q <= fire_q;
			pend_tag_q  <= tag_a[fire_q];
		end
		if (state_q == ST_EMIT && out_free) out_q <= res_q;
	end

	assign out_valid    = out_valid_q;
	assign slot_out     = out_q.slot;
	assign tag_out      = out_q.tag;
	assign ok           = out_q.ok;
	assign fired        = out_q.fired;
	assign front_wake   = out_q.wake;
	assign none_pending = out_q.none;
	assign wait_ms      = out_q.wait_ms;
	assign last         = out_q.last;

	a_fire_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FIRE |-> n_q < N_W'(MAX_RESULTS))
		else $error("fire count past result bound");

	a_scan_len: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SCAN |-> cnt_q <= CNT_W'(SLOTS))
		else $error("scan counter overran the chain length");

	a_fire_active: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FIRE |-> active_v[fire_q])
		else $error("firing a slot that is not active");

	a_sel_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(cell_sel))
		else $error("more than one cell selected");

endmodule

`default_nettype wire

[dv/dtq_checker.sv]
// dtq_checker: watches the item, config and result channels of deadline_timer_queue,
// predicts every result beat from its own timer table and compares; depends on dtq_pkg
`default_nettype none

module dtq_checker (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	input  wire logic                          in_stall,
	input  wire logic [dtq_pkg::FUNC_W-1:0]    func,
	input  wire logic [dtq_pkg::TIME_W-1:0]    now_ms,
	input  wire logic [dtq_pkg::SEL_W-1:0]     slot_sel,
	input  wire logic [dtq_pkg::PERIOD_W-1:0]  period_ms,
	input  wire logic                          repeats,
	input  wire logic                          start_now,
	input  wire logic [dtq_pkg::TAG_W-1:0]     tag_in,
	input  wire logic                          cfg_valid,
	input  wire logic                          cfg_ready,
	input  wire logic [dtq_pkg::PERIOD_W-1:0]  cfg_data,
	input  wire logic                          out_valid,
	input  wire logic                          out_stall,
	input  wire logic [dtq_pkg::SEL_W-1:0]     slot_out,
	input  wire logic [dtq_pkg::TAG_W-1:0]     tag_out,
	input  wire logic                          ok,
	input  wire logic                          fired,
	input  wire logic                          front_wake,
	input  wire logic                          none_pending,
	input  wire logic [dtq_pkg::TIME_W-1:0]    wait_ms,
	input  wire logic                          last,
	output int                                 errors,
	output int                                 pending
);
	import dtq_pkg::*;

	localparam int NSLOT = SLOTS_DEF;

	logic                tm_active [NSLOT];
	logic                tm_rep    [NSLOT];
	logic [PERIOD_W-1:0] tm_period [NSLOT];
	logic [TIME_W-1:0]   tm_dl     [NSLOT];
	logic [TAG_W-1:0]    tm_tag    [NSLOT];
	logic                wake_pend;
	logic [TIME_W-1:0]   last_exp;
	logic [PERIOD_W-1:0] window;

	result_t beats_due[$];

	function automatic logic [TIME_W-1:0] plus_sat(logic [TIME_W-1:0] t,
			logic [PERIOD_W-1:0] p);
		logic [TIME_W:0] s;
		s = {1'b0, t} + {(TIME_W - PERIOD_W + 1)'(0), p};
		return s[TIME_W] ? TIME_MAX : s[TIME_W-1:0];
	endfunction

	function automatic bit earlier(int a, int b);
		return tm_dl[a] < tm_dl[b] || (tm_dl[a] == tm_dl[b] && a < b);
	endfunction

	function automatic bit claim_wake(int s);
		for (int t = 0; t < NSLOT; t++)
			if (t != s && tm_active[t] && earlier(t, s))
				return 0;
		if (wake_pend)
			return 0;
		wake_pend = 1;
		return 1;
	endfunction

	function automatic result_t mk(logic [SEL_W-1:0] sl, logic [TAG_W-1:0] tg, logic k,
			logic fi, logic w, logic nn, logic [TIME_W-1:0] wt, logic ls);
		result_t r;
		r.slot = sl; r.tag = tg; r.ok = k; r.fired = fi; r.wake = w;
		r.none = nn; r.wait_ms = wt; r.last = ls;
		return r;
	endfunction

	// single final beat carrying only ok
	function automatic result_t plain(logic k);
		result_t r;
		r = '0;
		r.ok = k;
		r.last = 1'b1;
		return r;
	endfunction

	function automatic void expect_beat(result_t r);
		beats_due = {beats_due, r};
	endfunction

	task automatic predict_item();
		int f, b, n;
		bit roll, w;
		bit due [NSLOT];
		logic [TIME_W-1:0] start;
		int s;
		s = slot_sel;
		case (func)
			FN_ADD: begin
				f = -1;
				for (int i = NSLOT - 1; i >= 0; i--)
					if (!tm_active[i]) f = i;
				if (f < 0) begin
					expect_beat(plain(1'b0));
				end else begin
					tm_active[f] = 1; tm_rep[f] = repeats; tm_period[f] = period_ms;
					tm_dl[f] = plus_sat(now_ms, period_ms); tm_tag[f] = tag_in;
					w = claim_wake(f);
					expect_beat(mk(SEL_W'(f), '0, 1'b1, 1'b0, w, 1'b0, '0, 1'b1));
				end
			end
			FN_CANCEL: begin
				if (tm_active[s]) tm_active[s] = 0;
				else begin expect_beat(plain(1'b0)); return; end
				expect_beat(plain(1'b1));
			end
			FN_REFRESH: begin
				if (tm_active[s]) tm_dl[s] = plus_sat(now_ms, tm_period[s]);
				expect_beat(plain(tm_active[s]));
			end
			FN_RESET: begin
				if (period_ms == tm_period[s] && !start_now) begin
					expect_beat(plain(1'b1));
				end else if (!tm_active[s]) begin
					expect_beat(plain(1'b0));
				end else begin
					if (start_now) start = now_ms;
					else start = tm_dl[s] >= TIME_W'(tm_period[s])
						? tm_dl[s] - TIME_W'(tm_period[s]) : '0;
					tm_period[s] = period_ms;
					tm_dl[s] = plus_sat(start, period_ms);
					w = claim_wake(s);
					expect_beat(mk('0, '0, 1'b1, 1'b0, w, 1'b0, '0, 1'b1));
				end
			end
			FN_EXPIRE: begin
				roll = last_exp > TIME_W'(window) && now_ms < last_exp - TIME_W'(window);
				last_exp = now_ms;
				for (int i = 0; i < NSLOT; i++)
					due[i] = tm_active[i] && (roll || tm_dl[i] <= now_ms);
				n = 0;
				while (n < MAX_RESULTS) begin
					b = -1;
					for (int i = 0; i < NSLOT; i++)
						if (due[i] && (b < 0 || earlier(i, b))) b = i;
					if (b < 0) break;
					due[b] = 0;
					expect_beat(mk(SEL_W'(b), tm_tag[b], 1'b1, 1'b1, 1'b0, 1'b0, '0, 1'b0));
					if (tm_rep[b]) tm_dl[b] = plus_sat(now_ms, tm_period[b]);
					else tm_active[b] = 0;
					n++;
				end
				if (n == 0) expect_beat(plain(1'b1));
				else beats_due[$].last = 1;
			end
			FN_QUERY: begin
				wake_pend = 0;
				b = -1;
				for (int i = 0; i < NSLOT; i++)
					if (tm_active[i] && (b < 0 || earlier(i, b))) b = i;
				if (b < 0) expect_beat(mk('0, '0, 1'b1, 1'b0, 1'b0, 1'b1, TIME_MAX, 1'b1));
				else expect_beat(mk('0, '0, 1'b1, 1'b0, 1'b0, 1'b0,
					now_ms >= tm_dl[b] ? '0 : tm_dl[b] - now_ms, 1'b1));
			end
			default: expect_beat(plain(1'b0));
		endcase
	endtask

	task automatic cmp(string name, logic [TIME_W-1:0] exp_v, logic [TIME_W-1:0] act_v);
		if (exp_v !== act_v) begin
			$error("%s mismatch: expected %0h actual %0h", name, exp_v, act_v);
			errors++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t e;
		if (!arst_n) begin
			for (int i = 0; i < NSLOT; i++) begin
				tm_active[i] = 0; tm_rep[i] = 0; tm_period[i] = 0;
				tm_dl[i] = 0; tm_tag[i] = 0;
			end
			wake_pend = 0; last_exp = 0; window = WINDOW_RESET;
			beats_due.delete();
			errors = 0; pending = 0;
		end else begin
			if (cfg_valid && cfg_ready) window = cfg_data;
			if (out_valid && !out_stall) begin
				if (beats_due.size() == 0) begin
					$error("result beat with nothing expected");
					errors++;
				end else begin
					e = beats_due.pop_front();
					cmp("slot_out", TIME_W'(e.slot), TIME_W'(slot_out));
					cmp("tag_out", TIME_W'(e.tag), TIME_W'(tag_out));
					cmp("ok", TIME_W'(e.ok), TIME_W'(ok));
					cmp("fired", TIME_W'(e.fired), TIME_W'(fired));
					cmp("front_wake", TIME_W'(e.wake), TIME_W'(front_wake));
					cmp("none_pending", TIME_W'(e.none), TIME_W'(none_pending));
					cmp("wait_ms", e.wait_ms, wait_ms);
					cmp("last", TIME_W'(e.last), TIME_W'(last));
				end
			end
			if (in_valid && !in_stall) predict_item();
			pending = beats_due.size();
		end
	end
endmodule

`default_nettype wire

[dv/tb.sv]
// tb: stimulus and verdict for deadline_timer_queue; timer-table sequences, config
// phases and backpressure; checking lives in dtq_checker; depends on dtq_pkg
`default_nettype none

module tb;
	import dtq_pkg::*;

	logic                clk = 0;
	logic                arst_n = 0;
	logic                in_valid = 0;
	logic                in_stall;
	logic [FUNC_W-1:0]   func = FN_QUERY;
	logic [TIME_W-1:0]   now_ms = '0;
	logic [SEL_W-1:0]    slot_sel = '0;
	logic [PERIOD_W-1:0] period_ms = '0;
	logic                repeats = 0;
	logic                start_now = 0;
	logic [TAG_W-1:0]    tag_in = '0;
	logic                cfg_valid = 0;
	logic                cfg_ready;
	logic [PERIOD_W-1:0] cfg_data = '0;
	logic                out_valid;
	logic                out_stall = 1;
	logic [SEL_W-1:0]    slot_out;
	logic [TAG_W-1:0]    tag_out;
	logic                ok, fired, front_wake, none_pending, last;
	logic [TIME_W-1:0]   wait_ms;
	int                  errors, pending;
	int                  idle_cycles = 0;
	bit                  hold_long = 0;
	logic [TIME_W-1:0]   clock_ms = 48'd1000;

	localparam int LIMIT = 20000;

	always begin
		#4 clk = 1;
		#4 clk = 0;
	end

	deadline_timer_queue DUT (.*);

	dtq_checker u_chk (.*);

	// receiver: random stalls per beat, one long hold-off on request
	initial begin
		int w;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_long) begin
				out_stall <= 1;
				repeat (300) @(negedge clk);
				hold_long = 0;
			end
			w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
			if (w == 0) out_stall <= 0;
			else begin
				out_stall <= 1;
				repeat (w) @(negedge clk);
				out_stall <= 0;
			end
			do @(posedge clk); while (!(out_valid && !out_stall));
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	task automatic send(logic [FUNC_W-1:0] f, logic [SEL_W-1:0] s, logic [PERIOD_W-1:0] p,
			logic r, logic fn, logic [TAG_W-1:0] t, bit gaps);
		int w;
		w = gaps ? (($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 13)) : 0;
		if (w > 0) begin
			in_valid <= 0;
			repeat (w) @(negedge clk);
		end
		func <= f; now_ms <= clock_ms; slot_sel <= s; period_ms <= p;
		repeats <= r; start_now <= fn; tag_in <= t;
		in_valid <= 1;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid <= 0;
		while (pending != 0) @(negedge clk);
		repeat (400) @(negedge clk);
	endtask

	task automatic write_window(logic [PERIOD_W-1:0] v);
		drain();
		cfg_data <= v; cfg_valid <= 1;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 0;
	endtask

	task automatic rand_item(bit gaps);
		int k;
		logic [PERIOD_W-1:0] p;
		logic [FUNC_W-1:0] f;
		k = $urandom_range(0, 99);
		case ($urandom_range(0, 3))
			0: p = $urandom;
			1: p = $urandom_range(0, 3);
			default: p = $urandom_range(0, 5000);
		endcase
		// time mostly moves forward, sometimes jumps back, jumps to a random value or sits near the top
		case ($urandom_range(0, 19))
			0: clock_ms = clock_ms - TIME_W'($urandom_range(0, 8000000));
			1: clock_ms = TIME_W'({$urandom, $urandom});
			2: clock_ms = TIME_MAX - TIME_W'($urandom_range(0, 3000));
			default: clock_ms = clock_ms + TIME_W'($urandom_range(0, 3000));
		endcase
		if (k < 30) f = FN_ADD;
		else if (k < 40) f = FN_CANCEL;
		else if (k < 48) f = FN_REFRESH;
		else if (k < 58) f = FN_RESET;
		else if (k < 82) f = FN_EXPIRE;
		else if (k < 97) f = FN_QUERY;
		else f = ($urandom_range(0, 1) == 0) ? FN_SPARE6 : FN_SPARE7;
		send(f, 4'($urandom), p, 1'($urandom), 1'($urandom), 16'($urandom), gaps);
	endtask

	initial begin
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		// directed: extremes, every operation, full table, saturation, rollover
		send(FN_QUERY, 0, 0, 0, 0, 0, 0);
		send(FN_EXPIRE, 0, 0, 0, 0, 0, 0);
		send(FN_CANCEL, 4'hf, 0, 0, 0, 0, 0);
		send(FN_RESET, 4'h3, 0, 0, 0, 0, 0);
		send(FN_RESET, 4'h3, 5, 0, 1, 0, 0);
		for (int i = 0; i < 17; i++)
			send(FN_ADD, 0, (i == 0) ? '1 : PERIOD_W'(i * 10), i[0], 0,
				TAG_W'(32'hffff - i), 0);
		send(FN_REFRESH, 4'h2, 0, 0, 0, 0, 0);
		send(FN_RESET, 4'h4, 7, 0, 0, 0, 0);
		send(FN_RESET, 4'h5, 9, 0, 1, 0, 0);
		send(FN_SPARE6, 0, 0, 0, 0, 0, 0);
		send(FN_SPARE7, 4'hf, '1, 1, 1, '1, 0);
		clock_ms = TIME_MAX;
		send(FN_ADD, 0, '1, 1, 0, 0, 0);
		send(FN_EXPIRE, 0, 0, 0, 0, 0, 0);
		send(FN_QUERY, 0, 0, 0, 0, 0, 0);
		clock_ms = 48'd5;
		send(FN_EXPIRE, 0, 0, 0, 0, 0, 0);
		// random phases across window settings
		write_window(32'd0);
		for (int i = 0; i < 100; i++) rand_item(1);
		hold_long = 1;
		for (int i = 0; i < 40; i++) rand_item(0);
		drain();
		write_window(32'hffff_ffff);
		for (int i = 0; i < 100; i++) rand_item(1);
		write_window(32'd1000);
		for (int i = 0; i < 100; i++) rand_item(1);
		write_window(32'd3600000);
		for (int i = 0; i < 90; i++) rand_item(1);
		drain();
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end
endmodule

`default_nettype wire

[files.f]
hw/rtl/dtq_pkg.sv
hw/rtl/dtq_cell.sv
hw/rtl/deadline_timer_queue.sv
dv/dtq_checker.sv
dv/tb.sv
